/* design/sorted_key_table_search_macros.svh */
// ----------------------------------------------------------------------------
// Sorted key table search: assertion macros
// Concurrent check wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_SEARCH_MACROS_SVH
`define SORTED_KEY_TABLE_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SKS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SKS_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define SKS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* design/sks_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted key table search package
// Word types, request and status codes, controller states, command/status.
// ----------------------------------------------------------------------------
package sks_pkg;

   localparam int SKS_TABLE_DEPTH = 256;
   localparam int SKS_KEY_WIDTH   = 32;
   localparam int SKS_KEY_IN_W    = 32;
   localparam int SKS_INDEX_W     = 8;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_SORT   = 2'd1,
      OP_SEARCH = 2'd2,
      OP_CLEAR  = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      RS_OK   = 2'd0,
      RS_MISS = 2'd1,
      RS_FULL = 2'd2
   } rsp_status_type;

   typedef enum logic [1:0] {
      IDX_ZERO  = 2'd0,
      IDX_COUNT = 2'd1,
      IDX_MID   = 2'd2
   } idx_sel_type;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [SKS_KEY_IN_W-1:0] key;
   } req_word_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [SKS_INDEX_W-1:0] entry_index;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_APPEND,
      S_CLEAR,
      S_SRCH_START,
      S_SRCH_PROBE,
      S_SORT_START,
      S_SORT_LOAD,
      S_SORT_CMP,
      S_SORT_PUT,
      S_RESULT
   } sks_state_type;

   typedef struct packed {
      logic           capture;     // latch request key
      logic           append;      // write key at count, count++
      logic           clear;       // count = 0
      logic           srch_start;  // init bounds, read first probe
      logic           srch_step;   // narrow bounds, read next probe
      logic           sort_start;  // i = 1, read entry 1
      logic           sort_load;   // v = entry i, j = i, read j-1
      logic           sort_shift;  // entry j = entry j-1, j--, read j-2
      logic           sort_put;    // entry j = v, i++, read i+1
      logic           res_set;
      rsp_status_type res_status;
      idx_sel_type    res_idx_sel;
      logic           rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_lt2;
      logic count_full;
      logic hit;         // probed key equals search key
      logic less;        // probed key below search key
      logic more_lt;     // range left above the probe
      logic more_gt;     // range left below the probe
      logic shift_gt;    // entry j-1 above held key
      logic j_gt1;
      logic i_more;      // another element to insert
      logic rsp_free;
   } dp_status_type;

endpackage

/* design/sks_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted key table search controller
// Sequences append, clear, binary search and insertion sort commands.
// ----------------------------------------------------------------------------
module sks_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  sks_pkg::req_word_type  req_word,
   output logic                   req_stall,
   input  sks_pkg::dp_status_type dp_stat,
   output sks_pkg::dp_cmd_type    cmd
);
   import sks_pkg::*;

   sks_state_type state_ff, state_in;
   op_code_type   req_op;

   assign req_op = op_code_type'(req_word.req_type);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_APPEND: state_in = S_APPEND;
                  OP_SORT:   state_in = S_SORT_START;
                  OP_SEARCH: state_in = S_SRCH_START;
                  OP_CLEAR:  state_in = S_CLEAR;
               endcase
            end
         end
         S_APPEND, S_CLEAR: state_in = S_RESULT;
         S_SRCH_START: state_in = dp_stat.count_zero ? S_RESULT : S_SRCH_PROBE;
         S_SRCH_PROBE: begin
            priority if (dp_stat.hit) begin
               state_in = S_RESULT;
            end else if (dp_stat.less ? dp_stat.more_lt : dp_stat.more_gt) begin
               state_in = S_SRCH_PROBE;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_SORT_START: state_in = dp_stat.count_lt2 ? S_RESULT : S_SORT_LOAD;
         S_SORT_LOAD:  state_in = S_SORT_CMP;
         S_SORT_CMP: begin
            state_in = (dp_stat.shift_gt && dp_stat.j_gt1) ? S_SORT_CMP : S_SORT_PUT;
         end
         S_SORT_PUT: state_in = dp_stat.i_more ? S_SORT_LOAD : S_RESULT;
         S_RESULT:   state_in = dp_stat.rsp_free ? S_IDLE : S_RESULT;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_APPEND: begin
            cmd.res_set = 1'b1;
            if (dp_stat.count_full) begin
               cmd.res_status  = RS_FULL;
               cmd.res_idx_sel = IDX_ZERO;
            end else begin
               cmd.append      = 1'b1;
               cmd.res_status  = RS_OK;
               cmd.res_idx_sel = IDX_COUNT;
            end
         end
         S_CLEAR: begin
            cmd.clear       = 1'b1;
            cmd.res_set     = 1'b1;
            cmd.res_status  = RS_OK;
            cmd.res_idx_sel = IDX_ZERO;
         end
         S_SRCH_START: begin
            if (dp_stat.count_zero) begin
               cmd.res_set     = 1'b1;
               cmd.res_status  = RS_MISS;
               cmd.res_idx_sel = IDX_ZERO;
            end else begin
               cmd.srch_start = 1'b1;
            end
         end
         S_SRCH_PROBE: begin
            if (dp_stat.hit) begin
               cmd.res_set     = 1'b1;
               cmd.res_status  = RS_OK;
               cmd.res_idx_sel = IDX_MID;
            end else begin
               cmd.srch_step = 1'b1;
               if (!(dp_stat.less ? dp_stat.more_lt : dp_stat.more_gt)) begin
                  cmd.res_set     = 1'b1;
                  cmd.res_status  = RS_MISS;
                  cmd.res_idx_sel = IDX_ZERO;
               end
            end
         end
         S_SORT_START: begin
            if (dp_stat.count_lt2) begin
               cmd.res_set     = 1'b1;
               cmd.res_status  = RS_OK;
               cmd.res_idx_sel = IDX_ZERO;
            end else begin
               cmd.sort_start = 1'b1;
            end
         end
         S_SORT_LOAD: cmd.sort_load = 1'b1;
         S_SORT_CMP:  cmd.sort_shift = dp_stat.shift_gt;
         S_SORT_PUT: begin
            cmd.sort_put = 1'b1;
            if (!dp_stat.i_more) begin
               cmd.res_set     = 1'b1;
               cmd.res_status  = RS_OK;
               cmd.res_idx_sel = IDX_ZERO;
            end
         end
         S_RESULT: cmd.rsp_load = dp_stat.rsp_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* design/sks_dpath.sv */
// ----------------------------------------------------------------------------
// Sorted key table search datapath
// Key memory, entry count, search bounds, sort indexes and result register.
// ----------------------------------------------------------------------------
`include "sorted_key_table_search_macros.svh"

module sks_dpath #(
   parameter int TABLE_DEPTH = sks_pkg::SKS_TABLE_DEPTH,
   parameter int KEY_WIDTH   = sks_pkg::SKS_KEY_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sks_pkg::dp_cmd_type    cmd,
   output sks_pkg::dp_status_type dp_stat,
   input  sks_pkg::req_word_type  req_word,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output sks_pkg::rsp_word_type  rsp_word
);
   import sks_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);
   localparam logic [CW-1:0] TWO_C   = CW'(2);

   // key memory: one write, one registered read per cycle
   logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;
   logic [IW-1:0]        rd_addr, wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;
   logic                 wr_en;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   logic [CW-1:0]        count_ff, count_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [KEY_WIDTH-1:0] v_ff, v_in;
   logic [CW-1:0]        lo_ff, lo_in, hi1_ff, hi1_in;   // range is [lo, hi1)
   logic [IW-1:0]        mid_ff, mid_in;
   logic [IW-1:0]        i_ff, i_in, j_ff, j_in;
   rsp_status_type       res_status_ff, res_status_in;
   logic [IW-1:0]        res_idx_ff, res_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_ff, rsp_in;

   logic [KEY_WIDTH+SKS_KEY_IN_W-1:0] key_ext;
   logic [CW-1:0] mid_c, lo_lt, mid_lt, mid_gt, start_mid, i_c, i_next;
   logic [IW+SKS_INDEX_W-1:0] idx_ext;

   assign key_ext   = {{KEY_WIDTH{1'b0}}, req_word.key};
   assign mid_c     = CW'(mid_ff);
   assign lo_lt     = mid_c + ONE_C;
   assign mid_lt    = lo_lt + ((hi1_ff - mid_c - TWO_C) >> 1);
   assign mid_gt    = lo_ff + ((mid_c - lo_ff - ONE_C) >> 1);
   assign start_mid = (count_ff - ONE_C) >> 1;
   assign i_c       = CW'(i_ff);
   assign i_next    = i_c + ONE_C;
   assign idx_ext   = {{SKS_INDEX_W{1'b0}}, res_idx_ff};

   always_comb begin
      dp_stat.count_zero = (count_ff == '0);
      dp_stat.count_lt2  = (count_ff < TWO_C);
      dp_stat.count_full = (count_ff == DEPTH_C);
      dp_stat.hit        = (rd_data_ff == key_ff);
      dp_stat.less       = (rd_data_ff < key_ff);
      dp_stat.more_lt    = (lo_lt < hi1_ff);
      dp_stat.more_gt    = (lo_ff < mid_c);
      dp_stat.shift_gt   = (rd_data_ff > v_ff);
      dp_stat.j_gt1      = (j_ff > IW'(1));
      dp_stat.i_more     = (i_next < count_ff);
      dp_stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // memory port steering
   always_comb begin
      rd_addr = mid_ff;
      wr_en   = 1'b0;
      wr_addr = j_ff;
      wr_data = v_ff;
      priority if (cmd.append) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IW-1:0];
         wr_data = key_ff;
      end else if (cmd.srch_start) begin
         rd_addr = start_mid[IW-1:0];
      end else if (cmd.srch_step) begin
         rd_addr = dp_stat.less ? mid_lt[IW-1:0] : mid_gt[IW-1:0];
      end else if (cmd.sort_start) begin
         rd_addr = IW'(1);
      end else if (cmd.sort_load) begin
         rd_addr = i_ff - IW'(1);
      end else if (cmd.sort_shift) begin
         rd_addr = j_ff - IW'(2);
         wr_en   = 1'b1;
         wr_data = rd_data_ff;
      end else if (cmd.sort_put) begin
         rd_addr = i_next[IW-1:0];
         wr_en   = 1'b1;
      end else begin
         rd_addr = mid_ff;
      end
   end

   always_comb begin
      count_in      = count_ff;
      key_in        = key_ff;
      v_in          = v_ff;
      lo_in         = lo_ff;
      hi1_in        = hi1_ff;
      mid_in        = mid_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.capture) begin
         key_in = key_ext[KEY_WIDTH-1:0];
      end
      if (cmd.append) begin
         count_in = count_ff + ONE_C;
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.srch_start) begin
         lo_in  = '0;
         hi1_in = count_ff;
         mid_in = start_mid[IW-1:0];
      end
      if (cmd.srch_step) begin
         if (dp_stat.less) begin
            lo_in  = lo_lt;
            mid_in = mid_lt[IW-1:0];
         end else begin
            hi1_in = mid_c;
            mid_in = mid_gt[IW-1:0];
         end
      end
      if (cmd.sort_start) begin
         i_in = IW'(1);
      end
      if (cmd.sort_load) begin
         v_in = rd_data_ff;
         j_in = i_ff;
      end
      if (cmd.sort_shift) begin
         j_in = j_ff - IW'(1);
      end
      if (cmd.sort_put) begin
         i_in = i_next[IW-1:0];
      end
      if (cmd.res_set) begin
         res_status_in = cmd.res_status;
         unique case (cmd.res_idx_sel)
            IDX_ZERO:  res_idx_in = '0;
            IDX_COUNT: res_idx_in = count_ff[IW-1:0];
            IDX_MID:   res_idx_in = mid_ff;
            default:   res_idx_in = '0;
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_in.status      = res_status_ff;
         rsp_in.entry_index = idx_ext[SKS_INDEX_W-1:0];
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      v_ff          <= v_in;
      lo_ff         <= lo_in;
      hi1_ff        <= hi1_in;
      mid_ff        <= mid_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `SKS_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_C, "count above depth")
   `SKS_ASSERT_IMPLIES(a_append_room, clock, reset, cmd.append, !dp_stat.count_full, "append when full")
   `SKS_ASSERT_NEXT(a_append_count, clock, reset, cmd.append, count_ff == $past(count_ff) + ONE_C, "append count step")
   `SKS_ASSERT_IMPLIES(a_probe_range, clock, reset, cmd.srch_step, lo_ff < hi1_ff, "probe on empty range")
   `SKS_ASSERT_IMPLIES(a_rsp_no_drop, clock, reset, cmd.rsp_load, dp_stat.rsp_free, "result word overwritten")

endmodule

/* design/sorted_key_table_search.sv */
// ----------------------------------------------------------------------------
// Sorted key table search
// Key table with append, stable sort, binary search and clear requests.
// ----------------------------------------------------------------------------
// Each request word returns one response word. Items are handled one at a
// time; the request side is stalled while one is in progress, and a finished
// response sits in an output register so the next request may start while
// it waits. Append and clear pass through their own state, and the result
// state loads the response register. A search makes at most ceil(log2(n+1))
// probes over n stored entries (9 for a full 256-entry table) through the
// single registered read port of the key memory, which returns one probe per
// cycle. A sort of under two entries goes to the result state; else insertion
// sort loads, compares and puts each entry in turn, moving one entry per
// cycle through that same port. An empty table reports not-found; an append
// to a full table reports table-full and stores nothing. Only entries below
// the count are used, so the key memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_key_table_search #(
   parameter int TABLE_DEPTH = sks_pkg::SKS_TABLE_DEPTH,
   parameter int KEY_WIDTH   = sks_pkg::SKS_KEY_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request word
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sks_pkg::req_word_type req_word,
   // response word
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sks_pkg::rsp_word_type rsp_word
);
   import sks_pkg::*;

   dp_cmd_type    cmd;      // controller -> datapath
   dp_status_type dp_stat;  // datapath -> controller

   // sequencer: one state per step of each request kind
   sks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   // key memory, count, search bounds, sort indexes, response register
   sks_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .dp_stat   (dp_stat),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

/* tb/sorted_key_table_search_tb.sv */
// ----------------------------------------------------------------------------
// Sorted key table search testbench
// Drives append, sort, search and clear words through the valid/stall ports,
// predicts every response word with a stable sort and the same probe order,
// and checks each response field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module sorted_key_table_search_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sks_pkg::*;

   localparam int unsigned ITEM_GOAL    = 1450;
   localparam int unsigned IDLE_PCT     = 38;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 20;
   // watchdog limit, well above the slowest legal run
   localparam int unsigned RUN_LIMIT_NS = 3_000_000;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the key table, queue of predicted responses
   // -------------------------------------------------------------------------
   class key_table_scoreboard;
      logic [SKS_KEY_WIDTH-1:0] stored_keys [SKS_TABLE_DEPTH];
      int unsigned  entry_total;
      rsp_word_type pending [$];
      int unsigned  mismatches;
      int unsigned  checked;
      int unsigned  found;
      int unsigned  missed;
      int unsigned  refused;
      int unsigned  sorts;

      function new();
         entry_total = 0;
         mismatches  = 0;
         checked     = 0;
         found       = 0;
         missed      = 0;
         refused     = 0;
         sorts       = 0;
      endfunction

      // stable insertion sort over the entries in use
      function void sort_entries();
         int unsigned i;
         int unsigned j;
         logic [SKS_KEY_WIDTH-1:0] held;
         for (i = 1; i < entry_total; i++) begin
            held = stored_keys[i];
            j = i;
            while (j > 0 && stored_keys[j-1] > held) begin
               stored_keys[j] = stored_keys[j-1];
               j--;
            end
            stored_keys[j] = held;
         end
      endfunction

      // probe at lo + (hi - lo) / 2, first equal entry wins
      function bit find_entry(input logic [SKS_KEY_WIDTH-1:0] wanted,
                              output int unsigned where);
         int lo;
         int hi;
         int mid;
         lo = 0;
         hi = int'(entry_total) - 1;
         where = 0;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (stored_keys[mid] < wanted) begin
               lo = mid + 1;
            end else if (stored_keys[mid] > wanted) begin
               hi = mid - 1;
            end else begin
               where = mid;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(input req_word_type w);
         rsp_word_type predicted;
         int unsigned  where;
         predicted.status      = RS_OK;
         predicted.entry_index = '0;
         case (w.req_type)
            OP_APPEND: begin
               if (entry_total < SKS_TABLE_DEPTH) begin
                  stored_keys[entry_total] = w.key[SKS_KEY_WIDTH-1:0];
                  predicted.entry_index = entry_total[SKS_INDEX_W-1:0];
                  entry_total++;
               end else begin
                  predicted.status = RS_FULL;
               end
            end
            OP_SORT: begin
               sort_entries();
               sorts++;
            end
            OP_SEARCH: begin
               if (find_entry(w.key[SKS_KEY_WIDTH-1:0], where))
                  predicted.entry_index = where[SKS_INDEX_W-1:0];
               else
                  predicted.status = RS_MISS;
            end
            default: begin
               entry_total = 0;
            end
         endcase
         pending.push_back(predicted);
      endfunction

      function void check_response(input rsp_word_type got);
         rsp_word_type want;
         if (pending.size() == 0) begin
            $display("%0t ns: unexpected response word, expected none, got status %0d index %0d",
                     $time, got.status, got.entry_index);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         checked++;
         case (want.status)
            RS_OK:   found++;
            RS_MISS: missed++;
            default: refused++;
         endcase
         if (got.status !== want.status) begin
            $display("%0t ns: status field mismatch, expected %0d got %0d",
                     $time, want.status, got.status);
            mismatches++;
         end
         if (got.entry_index !== want.entry_index) begin
            $display("%0t ns: entry_index mismatch, expected %0d got %0d",
                     $time, want.entry_index, got.entry_index);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sorted_key_table_search uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   key_table_scoreboard book = new();

   // shared knobs between the sender and the receiver
   bit          steady_phase = 1'b0;  // no idling on either side
   int unsigned holds_asked  = 0;     // receiver long hold-off requests
   int unsigned words_sent   = 0;

   // keys appended in the current session, used to aim searches at hits
   logic [SKS_KEY_WIDTH-1:0] session_keys [$];

   // -------------------------------------------------------------------------
   // Monitor: values sampled here are the ones present at the edge, since
   // every driver updates through nonblocking assignments.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            book.check_response(rsp_word);
         if (req_valid && !req_stall)
            book.note_request(req_word);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: random stall, quiet stretches, and a long counted hold-off
   // that lets the block back up into its request side.
   // -------------------------------------------------------------------------
   initial begin
      int unsigned hold_left;
      int unsigned holds_served;
      hold_left    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (steady_phase) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks. Each call starts and ends on a rising edge; valid stays
   // high across back-to-back words and drops only for an idle cycle.
   // -------------------------------------------------------------------------
   task automatic send_word(input op_code_type op, input logic [SKS_KEY_IN_W-1:0] key_value);
      req_word_type w;
      w.req_type = op;
      w.key      = key_value;
      while (!steady_phase && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      words_sent++;
   endtask

   // key families: wide random, tiny range (many duplicates), near the top,
   // and a cluster around a per-session base
   function automatic logic [SKS_KEY_IN_W-1:0] draw_address(input int unsigned style,
                                                             input logic [SKS_KEY_IN_W-1:0] base);
      case (style)
         0:       return $urandom;
         1:       return $urandom_range(15);
         2:       return 32'hFFFF_FFFF - $urandom_range(15);
         default: return base + $urandom_range(31);
      endcase
   endfunction

   // mostly stored keys (hits), some neighbors of them, the rest fresh
   function automatic logic [SKS_KEY_IN_W-1:0] draw_lookup(input int unsigned style,
                                                            input logic [SKS_KEY_IN_W-1:0] base);
      int unsigned roll;
      logic [SKS_KEY_IN_W-1:0] pick;
      roll = $urandom_range(99);
      if (session_keys.size() == 0 || roll >= 75)
         return draw_address(style, base);
      pick = session_keys[$urandom_range(session_keys.size() - 1)];
      if (roll < 55)
         return pick;
      return ($urandom_range(1) != 0) ? pick + 1 : pick - 1;
   endfunction

   // well-formed use: clear, fill, sort, look up; sometimes append after
   // the sort so later searches run over an unsorted tail
   task automatic run_table_session();
      int unsigned style;
      int unsigned count;
      int unsigned i;
      logic [SKS_KEY_IN_W-1:0] base;
      logic [SKS_KEY_IN_W-1:0] k;
      style = $urandom_range(3);
      base  = $urandom;
      count = ($urandom_range(9) == 0) ? $urandom_range(24, 64) : $urandom_range(1, 12);
      session_keys.delete();
      send_word(OP_CLEAR, $urandom);
      for (i = 0; i < count; i++) begin
         k = draw_address(style, base);
         send_word(OP_APPEND, k);
         session_keys.push_back(k);
      end
      if ($urandom_range(3) == 0)
         send_word(OP_SEARCH, draw_lookup(style, base));
      send_word(OP_SORT, $urandom);
      repeat ($urandom_range(3, 10))
         send_word(OP_SEARCH, draw_lookup(style, base));
      if ($urandom_range(2) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            k = draw_address(style, base);
            send_word(OP_APPEND, k);
            session_keys.push_back(k);
         end
         repeat (2)
            send_word(OP_SEARCH, draw_lookup(style, base));
      end
   endtask

   // any operation in any order, no clear first
   task automatic run_noise(input int unsigned count);
      int unsigned style;
      int unsigned i;
      logic [SKS_KEY_IN_W-1:0] base;
      style = $urandom_range(3);
      base  = $urandom;
      for (i = 0; i < count; i++)
         send_word(op_code_type'($urandom_range(3)), draw_lookup(style, base));
   endtask

   // fill every slot, push past full, then sort and search the whole table;
   // the descending fill (in equal pairs) makes a near-worst-case sort
   task automatic run_fill_session(input bit descending);
      int unsigned i;
      logic [SKS_KEY_IN_W-1:0] k;
      session_keys.delete();
      send_word(OP_CLEAR, $urandom);
      for (i = 0; i < SKS_TABLE_DEPTH; i++) begin
         k = descending ? 32'hFFFF_FFF0 - (i / 2) * 32'h01F0_1E03 : $urandom;
         send_word(OP_APPEND, k);
         session_keys.push_back(k);
      end
      repeat (3)
         send_word(OP_APPEND, $urandom);    // table full: refused
      send_word(OP_SEARCH, session_keys[SKS_TABLE_DEPTH - 1]);
      send_word(OP_SORT, $urandom);
      repeat (12)
         send_word(OP_SEARCH, draw_lookup(0, '0));
      send_word(OP_SEARCH, descending ? 32'hFFFF_FFF0 : 32'hFFFF_FFFF);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned fills;
      int unsigned roll;
      fills = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every operation, empty / unsorted / duplicate /
      // single-entry / cleared tables
      send_word(OP_SEARCH, 32'h0000_0000);   // empty table: not found
      send_word(OP_SORT,   32'hFFFF_FFFF);   // sort of nothing
      send_word(OP_APPEND, 32'hFFFF_FFFF);
      send_word(OP_APPEND, 32'h8000_0000);
      send_word(OP_APPEND, 32'h0000_0000);
      send_word(OP_APPEND, 32'h7FFF_FFFF);
      send_word(OP_APPEND, 32'h8000_0000);   // duplicate key
      send_word(OP_APPEND, 32'h0000_0001);
      send_word(OP_SEARCH, 32'h0000_0000);   // unsorted: probe order decides
      send_word(OP_SEARCH, 32'hFFFF_FFFF);
      send_word(OP_SORT,   32'h5555_5555);
      send_word(OP_SEARCH, 32'h0000_0000);
      send_word(OP_SEARCH, 32'h0000_0001);
      send_word(OP_SEARCH, 32'h7FFF_FFFF);
      send_word(OP_SEARCH, 32'h8000_0000);   // first equal entry met
      send_word(OP_SEARCH, 32'hFFFF_FFFF);
      send_word(OP_SEARCH, 32'hFFFF_FFFE);   // miss between entries
      send_word(OP_SEARCH, 32'h0000_0002);
      send_word(OP_CLEAR,  32'hAAAA_AAAA);
      send_word(OP_SEARCH, 32'h0000_0001);   // cleared: not found
      send_word(OP_APPEND, 32'h0000_00A5);
      send_word(OP_SORT,   32'h0000_0000);   // single entry
      send_word(OP_SEARCH, 32'h0000_00A5);

      // random: mostly well-formed sessions, some noise, two full-table
      // fills each opened by a long receiver hold-off, one quiet stretch
      while (words_sent < ITEM_GOAL) begin
         steady_phase = (words_sent >= 1100 && words_sent < 1300);
         if (fills == 0 && words_sent > 350) begin
            holds_asked++;
            run_fill_session(1'b0);
            fills++;
         end else if (fills == 1 && words_sent > 800) begin
            holds_asked++;
            run_fill_session(1'b1);
            fills++;
         end else begin
            roll = $urandom_range(99);
            if (roll < 80)
               run_table_session();
            else
               run_noise($urandom_range(4, 12));
         end
      end
      steady_phase = 1'b0;
      req_valid <= 1'b0;

      // drain, then give stray words a chance to show up
      while (book.pending.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d words: %0d done or found, %0d not found, %0d refused as full",
               book.checked, book.found, book.missed, book.refused);
      $display("including %0d sorts and two full-table fills", book.sorts);
      if (book.mismatches == 0 && book.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d responses outstanding", book.pending.size());
      $display("status: fail");
      $finish;
   end

endmodule

/* sorted_key_table_search.f */
+incdir+design
design/sks_pkg.sv
design/sks_ctrl.sv
design/sks_dpath.sv
design/sorted_key_table_search.sv
tb/sorted_key_table_search_tb.sv
